>>> src/erid_pkg.sv
// shared types and constants for the escape run-length image decoder
`default_nettype none

package erid_pkg;

  // stream codes
  localparam logic [7:0] ESC_BYTE     = 8'hED;
  localparam logic [7:0] CODE_END     = 8'h00;
  localparam logic [7:0] CODE_LITERAL = 8'h01;
  localparam logic [7:0] CODE_NOP     = 8'h02;

  // register reset values and indexes
  localparam logic [15:0] START_RESET = 16'h2000;
  localparam logic [15:0] LIMIT_RESET = 16'h8000;
  localparam int          CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd1;

  // decoder phases
  localparam logic [1:0] PH_NORMAL  = 2'd0;
  localparam logic [1:0] PH_ESCAPE  = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;
  localparam logic [1:0] PH_REPEAT  = 2'd3;

  // result kinds
  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_END = 1'b1;

  // queue sizes
  localparam int TQ_DEPTH = 4;
  localparam int TQ_AW    = 2;
  localparam int TQ_CW    = 3;
  localparam int RQ_DEPTH = 2;
  localparam int RQ_AW    = 1;
  localparam int RQ_CW    = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_file;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] write_address;
    logic [7:0]  fill_value;
    logic [7:0]  run_length;
    logic        past_limit;
  } result_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_file;
    logic       is_esc;
    logic       is_end;
    logic       is_lit;
    logic       is_nop;
  } token_t;

endpackage

`default_nettype wire

>>> src/escape_rle_image_decoder.sv
// top level of the escape run-length image decoder
//
// usage: compressed image bytes go in through a queue-style port (push/full,
// one word per accepted push, with new_file restarting the decoder at the
// start address before that byte). write descriptors come out through a
// queue-style port: while empty is low the oldest descriptor sits on result,
// and pop takes it. kind 1 marks the end of the image.
// config: cfg_valid/cfg_ready with cfg_index (0 start address, 1 limit
// address) and cfg_data; cfg_ready is always high, write only while idle.
// path: an accepted byte is stored classified in the byte queue, and its
// descriptor, if it yields one, is registered into the result queue.
// throughput: one byte per cycle while the result queue has room; the back
// end's single 17-bit add and limit compares per word set that figure.
// reset: both queues empty, phase normal, registers back to 0x2000/0x8000.
// stall: the result queue holds 2 words and the byte queue 4; when the
// receiver stops popping, full rises once both are filled.
`default_nettype none

module escape_rle_image_decoder (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            push,
  output logic                           full,
  input  erid_pkg::item_t                item,
  output logic                           empty,
  input  wire                            pop,
  output erid_pkg::result_t              result,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [erid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [15:0]                     cfg_data
);
  import erid_pkg::*;

  logic   tok_valid;
  token_t tok;
  logic   tok_pop;

  erid_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop)
  );

  erid_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // after reset nothing is waiting and input is open
  assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // end marker carries no run
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind == KIND_END) |->
      (result.run_length == 8'd0 && result.fill_value == 8'd0 && !result.past_limit))
    else $error("end marker with run data");

  // a word can only reach the result side after being accepted
  assert property (@(posedge clk) disable iff (rst)
    ($past(empty) && !empty && !$past(rst)) |-> $past(tok_valid))
    else $error("result appeared with no queued byte");

endmodule

`default_nettype wire

>>> src/erid_front.sv
// input side: classifies each byte and queues it for the back end
`default_nettype none

module erid_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  output logic             full,
  input  erid_pkg::item_t  item,
  output logic             tok_valid,
  output erid_pkg::token_t tok,
  input  wire              tok_pop
);
  import erid_pkg::*;

  token_t           mem [TQ_DEPTH];
  logic [TQ_AW-1:0] wr_ptr;
  logic [TQ_AW-1:0] rd_ptr;
  logic [TQ_CW-1:0] count;
  logic             do_push;
  token_t           tok_in;

  assign full      = (count == TQ_CW'(TQ_DEPTH));
  assign do_push   = push && !full;
  assign tok_valid = (count != '0);
  assign tok       = mem[rd_ptr];

  always_comb begin
    tok_in.data_byte = item.data_byte;
    tok_in.new_file  = item.new_file;
    tok_in.is_esc    = (item.data_byte == ESC_BYTE);
    tok_in.is_end    = (item.data_byte == CODE_END);
    tok_in.is_lit    = (item.data_byte == CODE_LITERAL);
    tok_in.is_nop    = (item.data_byte == CODE_NOP);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (tok_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, tok_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/erid_back.sv
// execution side: phase machine, address tracking, limit check, result queue
`default_nettype none

module erid_back (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             tok_valid,
  input  erid_pkg::token_t                tok,
  output logic                            tok_pop,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [erid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [15:0]                      cfg_data,
  output logic                            empty,
  input  wire                             pop,
  output erid_pkg::result_t               result
);
  import erid_pkg::*;

  // configuration
  logic [15:0] start_address;
  logic [15:0] limit_address;

  // decoder state
  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic [7:0]  pending;
  logic [7:0]  pending_next;
  logic [16:0] next_address;
  logic [16:0] next_address_next;
  logic        stopped;
  logic        stopped_next;

  // state as seen after an optional restart
  logic [1:0]  eff_phase;
  logic [7:0]  eff_pending;
  logic [16:0] eff_address;
  logic        eff_stopped;
  logic        halted;
  logic [7:0]  run_cnt;
  logic [16:0] sum;
  logic        past;
  logic        emit;
  logic        do_run;
  result_t     res;

  // result queue
  result_t          rq [RQ_DEPTH];
  logic [RQ_AW-1:0] rq_wr;
  logic [RQ_AW-1:0] rq_rd;
  logic [RQ_CW-1:0] rq_count;
  logic             rq_room;
  logic             rq_push;
  logic             rq_pop;

  assign cfg_ready = 1'b1;

  assign empty   = (rq_count == '0);
  assign result  = rq[rq_rd];
  assign rq_pop  = pop && !empty;
  assign rq_room = (rq_count != RQ_CW'(RQ_DEPTH)) || rq_pop;
  assign tok_pop = tok_valid && rq_room;
  assign rq_push = tok_pop && emit;

  always_comb begin
    eff_phase   = tok.new_file ? PH_NORMAL : phase;
    eff_pending = tok.new_file ? 8'd0 : pending;
    eff_address = tok.new_file ? {1'b0, start_address} : next_address;
    eff_stopped = tok.new_file ? 1'b0 : stopped;
    halted      = eff_stopped || (eff_address > {1'b0, limit_address});
    run_cnt     = (eff_phase == PH_REPEAT) ? eff_pending : 8'd1;
    sum         = eff_address + {9'd0, run_cnt};
    past        = (sum > {1'b0, limit_address});

    phase_next        = eff_phase;
    pending_next      = eff_pending;
    next_address_next = eff_address;
    stopped_next      = eff_stopped;
    emit              = 1'b0;
    do_run            = 1'b0;

    res.kind          = KIND_RUN;
    res.write_address = eff_address[15:0];
    res.fill_value    = tok.data_byte;
    res.run_length    = run_cnt;
    res.past_limit    = past;

    if (!halted) begin
      case (eff_phase)
        PH_NORMAL: begin
          if (tok.is_esc) begin
            phase_next = PH_ESCAPE;
          end else begin
            do_run = 1'b1;
          end
        end
        PH_ESCAPE: begin
          if (tok.is_end) begin
            phase_next     = PH_NORMAL;
            stopped_next   = 1'b1;
            emit           = 1'b1;
            res.kind       = KIND_END;
            res.fill_value = 8'd0;
            res.run_length = 8'd0;
            res.past_limit = 1'b0;
          end else if (tok.is_lit) begin
            phase_next = PH_LITERAL;
          end else if (tok.is_nop) begin
            phase_next = PH_NORMAL;
          end else begin
            pending_next = tok.data_byte;
            phase_next   = PH_REPEAT;
          end
        end
        PH_LITERAL: begin
          phase_next = PH_NORMAL;
          do_run     = 1'b1;
        end
        PH_REPEAT: begin
          phase_next   = PH_NORMAL;
          pending_next = 8'd0;
          do_run       = 1'b1;
        end
        default: begin
          phase_next = PH_NORMAL;
        end
      endcase
    end

    if (do_run) begin
      emit              = 1'b1;
      next_address_next = sum;
      if (past) begin
        stopped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= START_RESET;
      limit_address <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START: start_address <= cfg_data;
        REG_LIMIT: limit_address <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_NORMAL;
      pending      <= 8'd0;
      next_address <= {1'b0, START_RESET};
      stopped      <= 1'b0;
    end else if (tok_pop) begin
      phase        <= phase_next;
      pending      <= pending_next;
      next_address <= next_address_next;
      stopped      <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq[rq_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= '0;
      rq_rd    <= '0;
      rq_count <= '0;
    end else begin
      if (rq_push) begin
        rq_wr <= rq_wr + 1'b1;
      end
      if (rq_pop) begin
        rq_rd <= rq_rd + 1'b1;
      end
      case ({rq_push, rq_pop})
        2'b10: rq_count <= rq_count + 1'b1;
        2'b01: rq_count <= rq_count - 1'b1;
        default: rq_count <= rq_count;
      endcase
    end
  end

endmodule

`default_nettype wire
